// ===== rtl/core/rpm_pkg.sv =====
// rpm_pkg: shared types and constants for the rgb pixel modifier
// used by the stream interfaces and every module under rtl/core

package rpm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CH_W       = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd2;

    localparam logic [CH_W-1:0] MAX_VALUE_RESET = 8'd255;
    localparam logic [CH_W-1:0] CH_FULL         = 8'd255;

    // floor(s / 3) as (s * 683) >> 11, exact for s below 2048
    localparam int              SUM_W     = CH_W + 2;
    localparam logic [SUM_W-1:0] DIV3_MUL  = 10'd683;
    localparam int              DIV3_SHIFT = 11;

    typedef enum logic [1:0] {
        MODE_NEGATE    = 2'd0,
        MODE_QUANTIZE  = 2'd1,
        MODE_GRAYSCALE = 2'd2,
        MODE_FLIP      = 2'd3
    } mode_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic accept;
        logic flush;
        logic flip;
    } flip_ctl_t;

    typedef struct packed {
        logic valid;
        logic last;
    } drain_t;

endpackage

// ===== rtl/core/rpm_pixel_in_if.sv =====
// rpm_pixel_in_if: request channel carrying one input pixel or flush
// depends on rpm_pkg

interface rpm_pixel_in_if;
    logic                  valid;
    logic                  ready;
    logic [rpm_pkg::CH_W-1:0] red_in;
    logic [rpm_pkg::CH_W-1:0] green_in;
    logic [rpm_pkg::CH_W-1:0] blue_in;
    logic                  flush;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output flush, input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  input flush, output ready);
endinterface

// ===== rtl/core/rpm_pixel_out_if.sv =====
// rpm_pixel_out_if: request channel carrying one result pixel
// depends on rpm_pkg

interface rpm_pixel_out_if;
    logic                  valid;
    logic                  ready;
    logic [rpm_pkg::CH_W-1:0] red_out;
    logic [rpm_pkg::CH_W-1:0] green_out;
    logic [rpm_pkg::CH_W-1:0] blue_out;
    logic                  end_of_row;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output end_of_row, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input end_of_row, output ready);
endinterface

// ===== rtl/core/rpm_color.sv =====
// rpm_color: per-pixel negate, quantize and grayscale arithmetic
// depends on rpm_pkg

module rpm_color
(
    input  rpm_pkg::mode_t                mode,
    input  logic [rpm_pkg::CH_W-1:0]      max_value,
    input  rpm_pkg::pixel_t               pix,
    output rpm_pkg::pixel_t               result
);

    logic [rpm_pkg::SUM_W-1:0]                    sum;
    logic [2*rpm_pkg::SUM_W-1:0]                  prod;
    logic [rpm_pkg::CH_W-1:0]                     avg;

    function automatic logic [rpm_pkg::CH_W-1:0] negate_ch(
        input logic [rpm_pkg::CH_W-1:0] c,
        input logic [rpm_pkg::CH_W-1:0] m
    );
        negate_ch = (c > m) ? '0 : m - c;
    endfunction

    function automatic logic [rpm_pkg::CH_W-1:0] quant_ch(
        input logic [rpm_pkg::CH_W-1:0] c
    );
        quant_ch = c[rpm_pkg::CH_W-1] ? rpm_pkg::CH_FULL : '0;
    endfunction

    assign sum  = rpm_pkg::SUM_W'(pix.red) + rpm_pkg::SUM_W'(pix.green)
                + rpm_pkg::SUM_W'(pix.blue);
    assign prod = (2*rpm_pkg::SUM_W)'(sum) * (2*rpm_pkg::SUM_W)'(rpm_pkg::DIV3_MUL);
    assign avg  = prod[rpm_pkg::DIV3_SHIFT +: rpm_pkg::CH_W];

    always_comb
    begin
        unique case (mode)
            rpm_pkg::MODE_NEGATE:
            begin
                result.red   = negate_ch(pix.red, max_value);
                result.green = negate_ch(pix.green, max_value);
                result.blue  = negate_ch(pix.blue, max_value);
            end
            rpm_pkg::MODE_QUANTIZE:
            begin
                result.red   = quant_ch(pix.red);
                result.green = quant_ch(pix.green);
                result.blue  = quant_ch(pix.blue);
            end
            rpm_pkg::MODE_GRAYSCALE:
            begin
                result.red   = avg;
                result.green = avg;
                result.blue  = avg;
            end
            default:
            begin
                result = pix;
            end
        endcase
    end

endmodule

// ===== rtl/core/rpm_line_flip.sv =====
// rpm_line_flip: column counters and ping-pong line banks for row mirroring
// depends on rpm_pkg; read data is registered and appears in the cycle after the request

module rpm_line_flip
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rpm_pkg::flip_ctl_t            ctl,
    input  rpm_pkg::pixel_t               pix,
    input  logic [rpm_pkg::WIDTH_W-1:0]   width,
    output logic                          row_end,
    output rpm_pkg::drain_t               drain,
    output rpm_pkg::pixel_t               rdata
);

    rpm_pkg::pixel_t bank_a_mem [rpm_pkg::MAX_WIDTH];
    rpm_pkg::pixel_t bank_b_mem [rpm_pkg::MAX_WIDTH];

    logic [rpm_pkg::COL_W-1:0]   wc_reg, wc_next;
    logic [rpm_pkg::COL_W-1:0]   rc_reg, rc_next;
    logic                        fill_bank_reg, fill_bank_next;
    logic                        row_held_reg, row_held_next;
    logic                        rd_from_a_reg;
    rpm_pkg::pixel_t             rdata_a_reg, rdata_b_reg;

    logic [rpm_pkg::WIDTH_W-1:0] wc_ext, rc_ext, rev_idx;
    logic                        rc_in_range;
    logic [rpm_pkg::COL_W-1:0]   rd_idx;
    logic                        do_pixel, do_write;

    assign wc_ext      = rpm_pkg::WIDTH_W'(wc_reg);
    assign rc_ext      = rpm_pkg::WIDTH_W'(rc_reg);
    assign row_end     = (wc_ext + rpm_pkg::WIDTH_W'(1)) >= width;
    assign rc_in_range = rc_ext < width;
    assign rev_idx     = width - rpm_pkg::WIDTH_W'(1) - rc_ext;
    assign rd_idx      = rc_in_range ? rev_idx[rpm_pkg::COL_W-1:0] : '0;

    assign do_pixel    = ctl.accept && !ctl.flush;
    assign do_write    = do_pixel && ctl.flip;
    assign drain.valid = ctl.accept && row_held_reg && (ctl.flush || ctl.flip);
    assign drain.last  = !rc_in_range || ((rc_ext + rpm_pkg::WIDTH_W'(1)) >= width);
    assign rdata       = rd_from_a_reg ? rdata_a_reg : rdata_b_reg;

    always_comb
    begin
        wc_next        = wc_reg;
        rc_next        = rc_reg;
        fill_bank_next = fill_bank_reg;
        row_held_next  = row_held_reg;
        if (drain.valid)
        begin
            if (drain.last)
            begin
                row_held_next = 1'b0;
                rc_next       = '0;
            end
            else
            begin
                rc_next = rc_reg + rpm_pkg::COL_W'(1);
            end
        end
        if (do_pixel)
        begin
            wc_next = row_end ? '0 : wc_reg + rpm_pkg::COL_W'(1);
        end
        if (do_write && row_end)
        begin
            fill_bank_next = !fill_bank_reg;
            row_held_next  = 1'b1;
            rc_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg        <= '0;
            rc_reg        <= '0;
            fill_bank_reg <= 1'b0;
            row_held_reg  <= 1'b0;
        end
        else
        begin
            wc_reg        <= wc_next;
            rc_reg        <= rc_next;
            fill_bank_reg <= fill_bank_next;
            row_held_reg  <= row_held_next;
        end
    end

    // held row sits in the bank not being filled
    always_ff @(posedge clk)
    begin
        if (drain.valid)
        begin
            rd_from_a_reg <= fill_bank_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write && !fill_bank_reg)
        begin
            bank_a_mem[wc_reg] <= pix;
        end
        if (drain.valid && fill_bank_reg)
        begin
            rdata_a_reg <= bank_a_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write && fill_bank_reg)
        begin
            bank_b_mem[wc_reg] <= pix;
        end
        if (drain.valid && !fill_bank_reg)
        begin
            rdata_b_reg <= bank_b_mem[rd_idx];
        end
    end

endmodule

// ===== rtl/core/rgb_pixel_modifier_top.sv =====
// rgb_pixel_modifier_top: configuration registers, result pipeline and skid output
// depends on rpm_pkg, rpm_pixel_in_if, rpm_pixel_out_if, rpm_color, rpm_line_flip

// One request is accepted per clock unless the output stalls, and results leave
// through the stage-one and output registers, in order. Negate, quantize and
// grayscale give one result per pixel. Horizontal flip writes each row into one
// of two line banks of 1024 entries and gives the previous row mirrored, one
// result per pixel once a row is held; the first row gives none. A flush request
// gives one held pixel if a row is held and writes nothing. The throughput figure
// is set by the single read port of each line bank, used once per request.
// Configuration writes belong between images, with no result outstanding.

module rgb_pixel_modifier_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpm_pkg::CFG_DATA_W-1:0]    cfg_data,
    rpm_pixel_in_if.sink                      pixel_in,
    rpm_pixel_out_if.source                   pixel_out
);

    rpm_pkg::mode_t                mode_reg;
    logic [rpm_pkg::CH_W-1:0]      max_value_reg;
    logic [rpm_pkg::WIDTH_W-1:0]   width_reg, width_next;

    logic                          accept, is_flip, direct;
    rpm_pkg::flip_ctl_t            flip_ctl;
    rpm_pkg::drain_t               drain;
    rpm_pkg::pixel_t               in_pix, color_pix, mem_pix, s1_out_pix;
    logic                          row_end;

    logic                          s1_valid_reg, s1_from_mem_reg, s1_eor_reg;
    rpm_pkg::pixel_t               s1_pix_reg;
    logic                          s1_adv, in_ready;

    logic                          out_valid_reg, out_eor_reg;
    rpm_pkg::pixel_t               out_pix_reg;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            width_next = rpm_pkg::WIDTH_W'(1);
        end
        else if (32'(cfg_data) > 32'(rpm_pkg::MAX_WIDTH))
        begin
            width_next = rpm_pkg::WIDTH_W'(rpm_pkg::MAX_WIDTH);
        end
        else
        begin
            width_next = rpm_pkg::WIDTH_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= rpm_pkg::MODE_NEGATE;
            max_value_reg <= rpm_pkg::MAX_VALUE_RESET;
            width_reg     <= rpm_pkg::WIDTH_W'(rpm_pkg::MAX_WIDTH);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rpm_pkg::CFG_MODE:
                begin
                    mode_reg <= rpm_pkg::mode_t'(cfg_data[1:0]);
                end
                rpm_pkg::CFG_MAX_VALUE:
                begin
                    max_value_reg <= cfg_data[rpm_pkg::CH_W-1:0];
                end
                rpm_pkg::CFG_ROW_WIDTH:
                begin
                    width_reg <= width_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign in_pix.red    = pixel_in.red_in;
    assign in_pix.green  = pixel_in.green_in;
    assign in_pix.blue   = pixel_in.blue_in;

    assign s1_adv         = s1_valid_reg && (!out_valid_reg || pixel_out.ready);
    assign in_ready       = !s1_valid_reg || s1_adv;
    assign pixel_in.ready = in_ready;
    assign accept         = pixel_in.valid && in_ready;
    assign is_flip        = mode_reg == rpm_pkg::MODE_FLIP;
    assign direct         = accept && !pixel_in.flush && !is_flip;

    assign flip_ctl.accept = accept;
    assign flip_ctl.flush  = pixel_in.flush;
    assign flip_ctl.flip   = is_flip;

    rpm_color u_color
    (
        .mode      (mode_reg),
        .max_value (max_value_reg),
        .pix       (in_pix),
        .result    (color_pix)
    );

    rpm_line_flip u_line_flip
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (flip_ctl),
        .pix     (in_pix),
        .width   (width_reg),
        .row_end (row_end),
        .drain   (drain),
        .rdata   (mem_pix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= direct || drain.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_from_mem_reg <= drain.valid;
            s1_eor_reg      <= drain.valid ? drain.last : row_end;
            s1_pix_reg      <= color_pix;
        end
    end

    assign s1_out_pix = s1_from_mem_reg ? mem_pix : s1_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixel_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pix_reg <= s1_out_pix;
            out_eor_reg <= s1_eor_reg;
        end
    end

    assign pixel_out.valid      = out_valid_reg;
    assign pixel_out.red_out    = out_pix_reg.red;
    assign pixel_out.green_out  = out_pix_reg.green;
    assign pixel_out.blue_out   = out_pix_reg.blue;
    assign pixel_out.end_of_row = out_eor_reg;

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("stage one result lost while stalled");

    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        direct |=> s1_valid_reg && !s1_from_mem_reg)
        else $error("direct mode request gave no arithmetic result");

    a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced result missing from output register");

endmodule
